// ----- hdl/utf8tw_pkg.sv -----
// Shared constants for the UTF-8 text width measurement block.
`timescale 1ns / 1ps

package utf8tw_pkg;

	// Request kinds carried in tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TEXT = 1'b1;

	// Field widths
	localparam int IDX_W   = 8;
	localparam int CODE_W  = 16;
	localparam int ADV_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int WIDTH_W = 16;
	localparam int CP_W    = 21;
	localparam int CNT_W   = 9;

	// Stream payload widths
	localparam int S_TDATA_W = IDX_W + CODE_W + ADV_W + BYTE_W;
	localparam int M_TDATA_W = WIDTH_W;

	// Register map
	localparam int          PADDR_W         = 3;
	localparam int          PDATA_W         = 32;
	localparam logic        REG_GLYPH_COUNT = 1'b0;

	// Replacement glyph
	localparam logic [CODE_W-1:0] QMARK = 16'h003F;

endpackage

// ----- hdl/utf8_text_width_measure.sv -----
// UTF-8 decoder with binary-search glyph lookup and wrapping width sum.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------------------
//  s_      | in        | s_tvalid/tready  | s_tdata: text byte or glyph entry, s_tuser: func
//  m_      | out       | m_tvalid/tready  | m_tdata: text_width
//  apb     | in        | psel/penable     | glyph_count at byte address 0
//
// A load request stays in the idle state. A text byte passes through a decode state and,
// for every binary search it starts, a probe and a compare state per probe plus a last
// probe state if the search misses: up to about log2(glyph_count)+1 probes per search,
// two searches per character when the '?' fallback runs, and a second decode pass and
// character when a broken sequence is followed by a new lead byte. A string end passes
// an emit state to hand over the width. The glyph memory has a single read port. Reset
// clears the decoder, the width and glyph_count; the glyph memory is not cleared. A result
// waiting on m_ stalls the block only when a second string end arrives before it is taken.
`timescale 1ns / 1ps

module utf8_text_width_measure
	import utf8tw_pkg::*;
#(
	parameter int MAX_GLYPHS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// text and table load requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] entry_index, [23:8] entry_code_point, [31:24] entry_advance, [39:32] text_byte
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                  s_tuser,
	// string widths
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [15:0] text_width
	output logic [M_TDATA_W-1:0]  m_tdata,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int CW = $clog2(MAX_GLYPHS + 1);
	localparam int LW = (CW > CNT_W) ? CW : CNT_W;
	localparam int XW = (IW > IDX_W) ? IW + 1 : IDX_W + 1;
	localparam int MW = CODE_W + ADV_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PROBE,
		ST_CMP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     glyph_count_q;
	logic [CP_W-1:0]      partial_q;
	logic [1:0]           rem_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [CODE_W-1:0]    target_q;
	logic                 fallback_q;
	logic                 again_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [IW-1:0]        mid_q;
	logic                 out_valid_q;
	logic [WIDTH_W-1:0]   out_data_q;

	// glyph memory: {code point, advance}
	logic [MW-1:0]        glyph_mem [MAX_GLYPHS];
	logic [MW-1:0]        rdata_q;

	// request fields
	logic [IDX_W-1:0]     in_index;
	logic [CODE_W-1:0]    in_code;
	logic [ADV_W-1:0]     in_adv;
	logic [BYTE_W-1:0]    in_byte;
	logic                 s_acc;
	logic                 load_en;

	// search datapath
	logic [LW-1:0]        limit_w;
	logic [CW-1:0]        limit;
	logic [CW-1:0]        mid_w;
	logic [IW-1:0]        mid;
	logic                 rd_en;
	logic [CODE_W-1:0]    rd_code;
	logic [ADV_W-1:0]     rd_adv;

	// decode datapath
	logic [CP_W-1:0]      partial_nx;
	logic                 is_cont;
	logic                 out_free;
	logic                 cfg_wr;

	assign in_index = s_tdata[IDX_W-1:0];
	assign in_code  = s_tdata[IDX_W +: CODE_W];
	assign in_adv   = s_tdata[IDX_W+CODE_W +: ADV_W];
	assign in_byte  = s_tdata[IDX_W+CODE_W+ADV_W +: BYTE_W];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign load_en  = s_acc && (s_tuser == FUNC_LOAD) &&
		(XW'(in_index) < XW'(MAX_GLYPHS));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = !out_valid_q || m_tready;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GLYPH_COUNT);
	assign prdata = (paddr[2] == REG_GLYPH_COUNT) ?
		PDATA_W'(glyph_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
		end else if (cfg_wr) begin
			glyph_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// search bounds and probe address
	assign limit_w = (LW'(glyph_count_q) > LW'(MAX_GLYPHS)) ?
		LW'(MAX_GLYPHS) : LW'(glyph_count_q);
	assign limit   = limit_w[CW-1:0];
	assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
	assign mid     = mid_w[IW-1:0];
	assign rd_en   = (state_q == ST_PROBE) && (lo_q < hi_q);
	assign rd_code = rdata_q[MW-1 -: CODE_W];
	assign rd_adv  = rdata_q[ADV_W-1:0];

	// glyph memory, one write and one read port
	always_ff @(posedge clk) begin
		if (load_en) begin
			glyph_mem[IW'(in_index)] <= {in_code, in_adv};
		end
		if (rd_en) begin
			rdata_q <= glyph_mem[mid];
		end
	end

	assign is_cont    = (byte_q[7:6] == 2'b10);
	assign partial_nx = {partial_q[CP_W-7:0], byte_q[5:0]};

	// sequencer: decode, search, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			partial_q   <= '0;
			rem_q       <= '0;
			width_q     <= '0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			target_q    <= '0;
			fallback_q  <= 1'b0;
			again_q     <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			out_data_q  <= '0;
		end else begin
			// result taken; the emit state refills it itself
			if (out_valid_q && m_tready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == FUNC_TEXT)) begin
						byte_q  <= in_byte;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					lo_q    <= '0;
					hi_q    <= limit;
					again_q <= 1'b0;
					if (rem_q != 2'd0) begin
						if (is_cont) begin
							// continuation byte
							rem_q <= rem_q - 2'd1;
							if (rem_q == 2'd1) begin
								partial_q <= '0;
								if (partial_nx[CP_W-1:CODE_W] != '0) begin
									target_q   <= QMARK;
									fallback_q <= 1'b0;
									state_q    <= ST_PROBE;
								end else if (partial_nx == '0) begin
									state_q <= ST_EMIT;
								end else begin
									target_q   <= partial_nx[CODE_W-1:0];
									fallback_q <= (partial_nx[CODE_W-1:0] != QMARK);
									state_q    <= ST_PROBE;
								end
							end else begin
								partial_q <= partial_nx;
								state_q   <= ST_IDLE;
							end
						end else begin
							// broken sequence: count '?', then take byte as lead
							rem_q      <= '0;
							partial_q  <= '0;
							target_q   <= QMARK;
							fallback_q <= 1'b0;
							again_q    <= 1'b1;
							state_q    <= ST_PROBE;
						end
					end else begin
						// lead byte
						case (byte_q) inside
							8'h00: begin
								state_q <= ST_EMIT;
							end
							[8'h01:8'h7F]: begin
								target_q   <= CODE_W'(byte_q);
								fallback_q <= (CODE_W'(byte_q) != QMARK);
								state_q    <= ST_PROBE;
							end
							[8'h80:8'hBF]: begin
								target_q   <= QMARK;
								fallback_q <= 1'b0;
								state_q    <= ST_PROBE;
							end
							[8'hC0:8'hDF]: begin
								partial_q <= CP_W'(byte_q[4:0]);
								rem_q     <= 2'd1;
								state_q   <= ST_IDLE;
							end
							[8'hE0:8'hEF]: begin
								partial_q <= CP_W'(byte_q[3:0]);
								rem_q     <= 2'd2;
								state_q   <= ST_IDLE;
							end
							default: begin
								partial_q <= CP_W'(byte_q[2:0]);
								rem_q     <= 2'd3;
								state_q   <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PROBE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else if (fallback_q) begin
						// not found: retry with '?'
						target_q   <= QMARK;
						fallback_q <= 1'b0;
						lo_q       <= '0;
						hi_q       <= limit;
					end else begin
						state_q <= again_q ? ST_DECODE : ST_IDLE;
					end
				end
				ST_CMP: begin
					if (rd_code == target_q) begin
						width_q <= width_q + WIDTH_W'(rd_adv);
						state_q <= again_q ? ST_DECODE : ST_IDLE;
					end else begin
						if (rd_code < target_q) begin
							lo_q <= CW'(mid_q) + CW'(1);
						end else begin
							hi_q <= CW'(mid_q);
						end
						state_q <= ST_PROBE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_data_q  <= width_q;
						out_valid_q <= 1'b1;
						width_q     <= '0;
						partial_q   <= '0;
						rem_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/utf8tw_chk.sv -----
// Port-level checks for the UTF-8 text width block, bound to the top level.
`timescale 1ns / 1ps

module utf8tw_chk
	import utf8tw_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 pready
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a text request always leaves the idle state for decode
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_TEXT) |=> !s_tready)
		else $error("text request did not start decode");

	// a table load does not stall the input
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_LOAD) |=> s_tready)
		else $error("table load stalled the input");

	// a new result only appears while the block is busy finishing a string
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind utf8_text_width_measure utf8tw_chk u_utf8tw_chk (.*);
